@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Types, constants and helper functions for the bottle fill sequencer.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int NUM_FLAGS = 11;

    // input flag bit positions
    localparam int F_START      = 0;
    localparam int F_STOP       = 1;
    localparam int F_POS        = 2;
    localparam int F_BOTTLE     = 3;
    localparam int F_BOTTLE_OLD = 4;
    localparam int F_BOTTLE_CH  = 5;
    localparam int F_PUMP       = 6;
    localparam int F_PUMP_OFF   = 7;
    localparam int F_PUMP_OLD   = 8;
    localparam int F_AUTO       = 9;
    localparam int F_STOP_LONG  = 10;

    // pin positions
    localparam int P_START  = 0;
    localparam int P_STOP   = 1;
    localparam int P_POS    = 2;
    localparam int P_BOTTLE = 3;
    localparam int P_PUMP   = 4;
    localparam int P_AUTO   = 5;

    localparam logic [3:0] PUMP_PULSE_LEN = 4'd10;
    localparam logic [4:0] STOP_DELAY_LEN = 5'd30;

    typedef logic [NUM_FLAGS-1:0] flags_t;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_CONTROL = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_ADVANCE = 3'd1,
        ST_WAIT    = 3'd2,
        ST_POUR    = 3'd3,
        ST_PINCH   = 3'd4,
        ST_WASH    = 3'd5
    } step_t;

    typedef enum logic [3:0] {
        REG_DEBOUNCE      = 4'd0,
        REG_PUMP_DEBOUNCE = 4'd1,
        REG_AUTO_DEBOUNCE = 4'd2,
        REG_LONG_STOP     = 4'd3,
        REG_ADVANCE_TO    = 4'd4,
        REG_BOTTLE_TO     = 4'd5,
        REG_PINCH_TIME    = 4'd6,
        REG_WASH_TIME     = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  debounce_limit;
        logic [7:0]  pump_debounce_limit;
        logic [7:0]  auto_debounce_limit;
        logic [11:0] long_stop_limit;
        logic [12:0] advance_timeout;
        logic [12:0] bottle_timeout;
        logic [12:0] pinch_time;
        logic [12:0] wash_time;
    } cfg_t;

    typedef struct packed {
        logic       advance_drive;
        logic       pour_drive;
        logic       pump_pulse;
        logic       ready_led;
        logic       pump_off_led;
        logic [2:0] step_code;
    } result_t;

    typedef struct packed {
        logic [11:0] cnt;
        logic        set;
        logic        clr;
    } deb_t;

    // Up/down debounce counter step; counts are zero-extended to 12 bits.
    function automatic deb_t debounce(input logic [11:0] cnt, input logic [11:0] lim,
                                      input logic active);
        deb_t r;
        r.cnt = cnt;
        r.set = 1'b0;
        r.clr = 1'b0;
        if (active) begin
            if (cnt < lim) begin
                r.cnt = cnt + 12'd1;
                r.set = (r.cnt == lim);
            end
        end else if (cnt != 12'd0) begin
            r.cnt = cnt - 12'd1;
            r.clr = (r.cnt == 12'd0);
        end
        return r;
    endfunction

    function automatic logic upd_flag(input logic old, input deb_t d);
        return d.set ? 1'b1 : (d.clr ? 1'b0 : old);
    endfunction

endpackage

@@ design/bfs_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_cfg
// Configuration register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module bfs_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [3:0]     wr_index,
    input  logic [12:0]    wr_data,
    output bfs_pkg::cfg_t  cfg
);
    import bfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_DEBOUNCE:      cfg_next.debounce_limit      = wr_data[7:0];
                REG_PUMP_DEBOUNCE: cfg_next.pump_debounce_limit = wr_data[7:0];
                REG_AUTO_DEBOUNCE: cfg_next.auto_debounce_limit = wr_data[7:0];
                REG_LONG_STOP:     cfg_next.long_stop_limit     = wr_data[11:0];
                REG_ADVANCE_TO:    cfg_next.advance_timeout     = wr_data;
                REG_BOTTLE_TO:     cfg_next.bottle_timeout      = wr_data;
                REG_PINCH_TIME:    cfg_next.pinch_time          = wr_data;
                REG_WASH_TIME:     cfg_next.wash_time           = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_limit      <= 8'd10;
            cfg_reg.pump_debounce_limit <= 8'd5;
            cfg_reg.auto_debounce_limit <= 8'd100;
            cfg_reg.long_stop_limit     <= 12'd2400;
            cfg_reg.advance_timeout     <= 13'd200;
            cfg_reg.bottle_timeout      <= 13'd20;
            cfg_reg.pinch_time          <= 13'd40;
            cfg_reg.wash_time           <= 13'd6000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/bfs_inputs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_inputs
// Pin debouncers, long-stop counter and the input flag register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfs_inputs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample,
    input  logic            control,
    input  logic [5:0]      pins,
    input  bfs_pkg::cfg_t   cfg,
    input  bfs_pkg::flags_t clr_mask,
    output bfs_pkg::flags_t flags,
    output bfs_pkg::flags_t flags_sample
);
    import bfs_pkg::*;

    logic [7:0]  short_cnt_reg [4];
    logic [7:0]  short_cnt_next [4];
    logic [7:0]  pump_cnt_reg, pump_cnt_next;
    logic [7:0]  auto_cnt_reg, auto_cnt_next;
    logic [11:0] long_cnt_reg, long_cnt_next;
    flags_t      flags_reg, flags_next;
    flags_t      fs;
    deb_t        d_short [4];
    deb_t        d_long, d_pump, d_auto;

    // sample tick: pins are active low
    always_comb
    begin
        fs = flags_reg;
        for (int i = 0; i < 4; i++)
        begin
            d_short[i] = debounce({4'd0, short_cnt_reg[i]}, {4'd0, cfg.debounce_limit},
                                  !pins[i]);
            short_cnt_next[i] = d_short[i].cnt[7:0];
        end
        fs[F_START]  = upd_flag(flags_reg[F_START],  d_short[P_START]);
        fs[F_STOP]   = upd_flag(flags_reg[F_STOP],   d_short[P_STOP]);
        fs[F_POS]    = upd_flag(flags_reg[F_POS],    d_short[P_POS]);
        fs[F_BOTTLE] = upd_flag(flags_reg[F_BOTTLE], d_short[P_BOTTLE]);

        d_long = debounce(long_cnt_reg, cfg.long_stop_limit, !pins[P_STOP]);
        long_cnt_next = d_long.cnt;
        fs[F_STOP_LONG] = upd_flag(flags_reg[F_STOP_LONG], d_long);

        if (fs[F_BOTTLE] && !flags_reg[F_BOTTLE_OLD])
            fs[F_BOTTLE_CH] = 1'b1;
        fs[F_BOTTLE_OLD] = fs[F_BOTTLE];

        d_pump = debounce({4'd0, pump_cnt_reg}, {4'd0, cfg.pump_debounce_limit},
                          !pins[P_PUMP]);
        pump_cnt_next = d_pump.cnt[7:0];
        fs[F_PUMP] = upd_flag(flags_reg[F_PUMP], d_pump);
        if (!fs[F_PUMP] && flags_reg[F_PUMP_OLD])
            fs[F_PUMP_OFF] = 1'b1;
        fs[F_PUMP_OLD] = fs[F_PUMP];

        d_auto = debounce({4'd0, auto_cnt_reg}, {4'd0, cfg.auto_debounce_limit},
                          !pins[P_AUTO]);
        auto_cnt_next = d_auto.cnt[7:0];
        fs[F_AUTO] = upd_flag(flags_reg[F_AUTO], d_auto);
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (sample)
            flags_next = fs;
        else if (control)
            flags_next = flags_reg & ~clr_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                short_cnt_reg[i] <= 8'd0;
            pump_cnt_reg <= 8'd0;
            auto_cnt_reg <= 8'd0;
            long_cnt_reg <= 12'd0;
            flags_reg    <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (sample)
            begin
                for (int i = 0; i < 4; i++)
                    short_cnt_reg[i] <= short_cnt_next[i];
                pump_cnt_reg <= pump_cnt_next;
                auto_cnt_reg <= auto_cnt_next;
                long_cnt_reg <= long_cnt_next;
            end
        end
    end

    assign flags        = flags_reg;
    assign flags_sample = fs;

    // old copies track their debounced flag after every sample tick
    `CHK_NEXT(a_bottle_old, sample, flags_reg[F_BOTTLE_OLD] == flags_reg[F_BOTTLE],
              "bottle old copy out of step")
    `CHK_NEXT(a_pump_old, sample, flags_reg[F_PUMP_OLD] == flags_reg[F_PUMP],
              "pump old copy out of step")
    `CHK_NEXT(a_ctrl_clear, control && clr_mask[F_STOP],
              !flags_reg[F_STOP], "stop flag not cleared by control tick")

endmodule

@@ design/bfs_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_seq
// Step sequencer, pump pulse counter and delayed stop on control ticks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfs_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              control,
    input  bfs_pkg::cfg_t     cfg,
    input  bfs_pkg::flags_t   flags,
    output bfs_pkg::flags_t   clr_mask,
    output bfs_pkg::result_t  res_ctrl,
    output bfs_pkg::result_t  res_hold
);
    import bfs_pkg::*;

    step_t       step_reg, step_next;
    logic [12:0] timer_reg, timer_next;
    logic [3:0]  pump_cnt_reg, pump_cnt_next;
    logic [4:0]  delay_reg, delay_next;
    logic        pend_reg, pend_next;
    logic [1:0]  drive_reg, drive_next;
    logic        ready_now;
    logic        expired;

    assign ready_now = (step_reg == ST_OFF) || (step_reg > ST_WASH);

    // next state
    always_comb
    begin
        step_next     = step_reg;
        timer_next    = timer_reg;
        pump_cnt_next = pump_cnt_reg;
        delay_next    = delay_reg;
        pend_next     = pend_reg;
        drive_next    = drive_reg;
        clr_mask      = '0;
        expired       = 1'b0;

        if (pump_cnt_next != 4'd0)
            pump_cnt_next = pump_cnt_next - 4'd1;

        if (flags[F_STOP])
        begin
            clr_mask[F_STOP] = 1'b1;
            if (pump_cnt_next != 4'd0)
                pend_next = 1'b1;
            else
            begin
                if (flags[F_PUMP])
                    pump_cnt_next = PUMP_PULSE_LEN;
                step_next  = ST_OFF;
                delay_next = 5'd0;
            end
        end

        // shared step timer; runs out on the tick it reaches zero
        if (step_next == ST_ADVANCE || step_next == ST_WAIT ||
            step_next == ST_PINCH || step_next == ST_WASH)
        begin
            if (timer_next != 13'd0)
            begin
                expired    = (timer_next == 13'd1);
                timer_next = timer_next - 13'd1;
            end
        end

        unique case (step_next)
            ST_ADVANCE:
            begin
                drive_next = 2'b01;
                if (expired)
                    step_next = ST_OFF;
                if (flags[F_POS])
                begin
                    step_next  = ST_WAIT;
                    timer_next = cfg.bottle_timeout;
                end
                clr_mask[F_PUMP_OFF] = 1'b1;
            end
            ST_WAIT:
            begin
                drive_next = 2'b00;
                if (expired)
                    step_next = ST_OFF;
                if (flags[F_BOTTLE_CH])
                begin
                    step_next             = ST_POUR;
                    pump_cnt_next         = PUMP_PULSE_LEN;
                    clr_mask[F_BOTTLE_CH] = 1'b1;
                end
            end
            ST_POUR:
            begin
                drive_next = 2'b10;
                if (flags[F_PUMP_OFF])
                begin
                    step_next            = ST_PINCH;
                    timer_next           = cfg.pinch_time;
                    clr_mask[F_PUMP_OFF] = 1'b1;
                end
            end
            ST_PINCH:
            begin
                drive_next = 2'b00;
                if (expired)
                begin
                    if (flags[F_AUTO])
                    begin
                        step_next             = ST_ADVANCE;
                        timer_next            = cfg.advance_timeout;
                        clr_mask[F_BOTTLE_CH] = 1'b1;
                    end
                    else
                        step_next = ST_OFF;
                end
            end
            ST_WASH:
            begin
                drive_next = 2'b10;
                if (flags[F_PUMP_OFF])
                begin
                    clr_mask[F_PUMP_OFF] = 1'b1;
                    pump_cnt_next        = PUMP_PULSE_LEN;
                end
                if (expired)
                begin
                    if (pump_cnt_next != 4'd0)
                        pend_next = 1'b1;
                    else
                    begin
                        if (flags[F_PUMP])
                            pump_cnt_next = PUMP_PULSE_LEN;
                        step_next  = ST_OFF;
                        delay_next = 5'd0;
                    end
                end
            end
            default:
            begin
                drive_next = 2'b00;
                if (flags[F_START])
                begin
                    clr_mask[F_START]     = 1'b1;
                    step_next             = ST_ADVANCE;
                    timer_next            = cfg.advance_timeout;
                    clr_mask[F_BOTTLE_CH] = 1'b1;
                end
                // long stop wins over start
                if (flags[F_STOP_LONG])
                begin
                    clr_mask[F_STOP_LONG] = 1'b1;
                    step_next             = ST_WASH;
                    timer_next            = cfg.wash_time;
                    pump_cnt_next         = PUMP_PULSE_LEN;
                    clr_mask[F_PUMP_OFF]  = 1'b1;
                end
                if (flags[F_PUMP])
                    drive_next[1] = 1'b1;
            end
        endcase

        // delayed stop: hold off until the pulse ends, then wait out the delay
        if (pend_next)
        begin
            if (pump_cnt_next != 4'd0)
                delay_next = STOP_DELAY_LEN;
            else if (delay_next != 5'd0)
            begin
                delay_next = delay_next - 5'd1;
                if (delay_next == 5'd0)
                begin
                    pend_next = 1'b0;
                    if (flags[F_PUMP])
                        pump_cnt_next = PUMP_PULSE_LEN;
                end
            end
        end
    end

    // result views
    always_comb
    begin
        res_ctrl.advance_drive = drive_next[0];
        res_ctrl.pour_drive    = drive_next[1];
        res_ctrl.pump_pulse    = (pump_cnt_next != 4'd0);
        res_ctrl.ready_led     = ready_now;
        res_ctrl.pump_off_led  = flags[F_PUMP_OFF];
        res_ctrl.step_code     = step_next;

        res_hold.advance_drive = drive_reg[0];
        res_hold.pour_drive    = drive_reg[1];
        res_hold.pump_pulse    = (pump_cnt_reg != 4'd0);
        res_hold.ready_led     = ready_now;
        res_hold.pump_off_led  = flags[F_PUMP_OFF];
        res_hold.step_code     = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ST_OFF;
            timer_reg    <= 13'd0;
            pump_cnt_reg <= 4'd0;
            delay_reg    <= 5'd0;
            pend_reg     <= 1'b0;
            drive_reg    <= 2'b00;
        end
        else if (control)
        begin
            step_reg     <= step_next;
            timer_reg    <= timer_next;
            pump_cnt_reg <= pump_cnt_next;
            delay_reg    <= delay_next;
            pend_reg     <= pend_next;
            drive_reg    <= drive_next;
        end
    end

    `CHK_ALWAYS(a_pulse_len, pump_cnt_reg <= PUMP_PULSE_LEN, "pump counter above pulse length")
    `CHK_ALWAYS(a_delay_len, delay_reg <= STOP_DELAY_LEN, "stop delay above its length")
    `CHK_IMPLY(a_delay_pend, delay_reg != 5'd0, pend_reg, "stop delay running without stop")
    `CHK_NEXT(a_hold_state, !control, $stable(step_reg) && $stable(pump_cnt_reg),
              "sequencer state moved without a control tick")

endmodule

@@ design/bottle_fill_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bottle_fill_sequencer
// Bottle filling cycle: pin debouncing, edge latching, step sequencer with
// timeouts, auto-repeat and a delayed stop; one result per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | input     | in_valid / in_ready  | operation, pins
//  out      | output    | out_valid / out_ready| advance_drive .. step_code
//  cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Each item waits in the input register, is processed in the transfer to
//  the result register, and is offered from there. Throughput is one item
//  per cycle while the output is not stalled, set by the single state update
//  path between the two registers. A stalled output holds both registers and
//  drops in_ready once the input register is full; rst_n clears all control
//  and sequencer state at once. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bottle_fill_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [5:0]  pins,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        advance_drive,
    output logic        pour_drive,
    output logic        pump_pulse,
    output logic        ready_led,
    output logic        pump_off_led,
    output logic [2:0]  step_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import bfs_pkg::*;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    op_t        s1_op_reg;
    logic [5:0] s1_pins_reg;

    // result register
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg, res_next;

    logic       adv;        // result register can take a new item
    logic       fire;       // item moves from input to result register
    logic       sample_tick;
    logic       control_tick;

    cfg_t       cfg;
    flags_t     flags, flags_sample, clr_mask;
    result_t    res_ctrl, res_hold;

    assign cfg_ready    = 1'b1;
    assign adv          = !out_valid_reg || out_ready;
    assign fire         = s1_valid_reg && adv;
    assign in_ready     = !s1_valid_reg || adv;
    assign sample_tick  = fire && (s1_op_reg == OP_SAMPLE);
    assign control_tick = fire && (s1_op_reg == OP_CONTROL);

    bfs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bfs_inputs u_inputs (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample_tick),
        .control      (control_tick),
        .pins         (s1_pins_reg),
        .cfg          (cfg),
        .clr_mask     (clr_mask),
        .flags        (flags),
        .flags_sample (flags_sample)
    );

    bfs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .control  (control_tick),
        .cfg      (cfg),
        .flags    (flags),
        .clr_mask (clr_mask),
        .res_ctrl (res_ctrl),
        .res_hold (res_hold)
    );

    // A sample tick reports the sequencer as it stands, with the pump-off
    // flag taken after the new pin sample.
    always_comb
    begin
        if (s1_op_reg == OP_CONTROL)
            res_next = res_ctrl;
        else
        begin
            res_next              = res_hold;
            res_next.pump_off_led = flags_sample[F_PUMP_OFF];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg   <= op_t'(operation);
            s1_pins_reg <= pins;
        end
        if (fire)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign advance_drive = res_reg.advance_drive;
    assign pour_drive    = res_reg.pour_drive;
    assign pump_pulse    = res_reg.pump_pulse;
    assign ready_led     = res_reg.ready_led;
    assign pump_off_led  = res_reg.pump_off_led;
    assign step_code     = res_reg.step_code;

    `CHK_NEXT(a_fire_result, fire, out_valid_reg, "processed item not offered")
    `CHK_NEXT(a_take_input, in_valid && in_ready, s1_valid_reg, "accepted item lost")
    `CHK_IMPLY(a_stall_hold, s1_valid_reg && out_valid_reg && !out_ready, !in_ready,
               "input taken while both stages are full")

endmodule
